FILE: hdl/piecewise_linear_key_index_assert.svh
// Assertion macros shared by the key index modules.
`ifndef PIECEWISE_LINEAR_KEY_INDEX_ASSERT_SVH
`define PIECEWISE_LINEAR_KEY_INDEX_ASSERT_SVH

// Same-cycle implication, ignored while reset is high.
`define PLKI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define PLKI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/plki_pkg.sv
// Types and constants shared by the piecewise linear key index modules.
package plki_pkg;

   // Field widths of the words on the two channels.
   localparam int KEY_FIELD_W  = 42;
   localparam int POS_FIELD_W  = 32;
   localparam int PRED_FIELD_W = 32;
   localparam int FAULT_W      = 2;

   // Quotients at or above 2^QUOT_BITS saturate the prediction.
   localparam int QUOT_BITS = 41;

   // Request kinds.
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_QUERY  = 1'b1;

   // Fault codes of a response.
   localparam logic [FAULT_W-1:0] FAULT_OK    = 2'd0;
   localparam logic [FAULT_W-1:0] FAULT_EMPTY = 2'd1;
   localparam logic [FAULT_W-1:0] FAULT_SPAN  = 2'd2;

   typedef struct packed {
      logic                   kind;
      logic [KEY_FIELD_W-1:0] key;
      logic [POS_FIELD_W-1:0] position;
   } req_type;

   typedef struct packed {
      logic [PRED_FIELD_W-1:0] prediction;
      logic [FAULT_W-1:0]      fault;
   } rsp_type;

   // Status of the interpolation unit as seen by the table sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } interp_status_type;

endpackage

FILE: hdl/plki_ram.sv
// Generic single-write, single-read RAM with registered read data.
module plki_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/plki_interp.sv
// Iterative interpolation unit: shift-add multiply, then restoring divide on one adder.
module plki_interp #(
   parameter int KEY_BITS = 42,
   parameter int POS_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [KEY_BITS-1:0]          ax,
   input  logic [POS_BITS-1:0]          ay,
   input  logic [KEY_BITS-1:0]          den,
   input  logic                         sign_diff,
   input  logic [POS_BITS-1:0]          ylo,
   output plki_pkg::interp_status_type  status,
   output logic [POS_BITS-1:0]          result
);

`include "piecewise_linear_key_index_assert.svh"

   localparam int KW    = KEY_BITS;
   localparam int PW    = POS_BITS;
   localparam int QB    = plki_pkg::QUOT_BITS;
   localparam int NW    = KW + PW + 2;
   localparam int CW    = KW + PW + QB + 2;
   localparam int STEPS = (QB > PW) ? QB : PW;
   localparam int RW    = STEPS + 1;
   localparam int CNTW  = $clog2(STEPS + 1);

   localparam logic [CNTW-1:0] LAST_MUL = CNTW'(PW - 1);
   localparam logic [CNTW-1:0] LAST_DIV = CNTW'(QB - 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL  = 3'd1;
   localparam logic [2:0] S_ADJ  = 3'd2;
   localparam logic [2:0] S_CMP  = 3'd3;
   localparam logic [2:0] S_DIV  = 3'd4;
   localparam logic [2:0] S_FIN  = 3'd5;

   logic [2:0]      state_ff, state_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [KW-1:0]   ax_ff, ax_in;
   logic [KW-1:0]   den_ff, den_in;
   logic            sign_ff, sign_in;
   logic [PW-1:0]   ylo_ff, ylo_in;
   logic [KW:0]     hi_ff, hi_in;
   logic [PW-1:0]   lo_ff, lo_in;
   logic [NW-1:0]   num_ff, num_in;
   logic            neg_ff, neg_in;
   logic            ovf_ff, ovf_in;
   logic [KW:0]     rem_ff, rem_in;
   logic [QB-1:0]   quo_ff, quo_in;
   logic [PW-1:0]   res_ff, res_in;
   logic            done_ff, done_in;

   // Shared adder operands.
   logic [KW+1:0]   opa, opb, opb_x;
   logic            sub;
   logic [KW+2:0]   total;
   logic            carry;

   // Adjust and compare steps.
   logic [KW+PW-1:0] prod;
   logic [KW+PW:0]   prod2;
   logic             neg_now, rounds_zero;
   logic [NW-1:0]    num_now;
   logic [CW-1:0]    num_ext, lim;
   logic             ovf_now;

   // Final rounding and saturation.
   logic [RW-1:0]    qw, yw, pmax, sum_w;
   logic [PW-1:0]    fin_res;

   // The one adder: accumulates the product, later trial-subtracts the divisor.
   always_comb begin
      if (state_ff == S_DIV) begin
         opa = {rem_ff, quo_ff[QB-1]};
         opb = {1'b0, den_ff, 1'b0};
         sub = 1'b1;
      end else begin
         opa = {1'b0, hi_ff};
         opb = lo_ff[0] ? (KW+2)'(ax_ff) : '0;
         sub = 1'b0;
      end
      opb_x = sub ? ~opb : opb;
      total = (KW+3)'(opa) + (KW+3)'(opb_x) + (KW+3)'(sub);
      carry = total[KW+2];
   end

   // Doubled product plus half the doubled divisor; results round to nearest, ties toward plus infinity.
   always_comb begin
      prod        = {hi_ff[KW-1:0], lo_ff};
      prod2       = {prod, 1'b0};
      neg_now     = sign_ff && (prod != '0);
      rounds_zero = neg_now && (prod2 <= (KW+PW+1)'(den_ff));
      num_now     = NW'(prod2) + NW'(den_ff) - NW'(neg_now);
      num_ext     = CW'(num_ff);
      lim         = CW'({den_ff, 1'b0}) << QB;
      ovf_now     = num_ext >= lim;
   end

   // Apply the quotient to the low position and clamp to the position range.
   always_comb begin
      qw    = RW'(quo_ff);
      yw    = RW'(ylo_ff);
      pmax  = RW'({PW{1'b1}});
      sum_w = yw + qw;
      if (ovf_ff) begin
         fin_res = neg_ff ? '0 : {PW{1'b1}};
      end else if (neg_ff) begin
         fin_res = (qw > yw) ? '0 : PW'(yw - qw);
      end else begin
         fin_res = (sum_w > pmax) ? {PW{1'b1}} : sum_w[PW-1:0];
      end
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      ax_in    = ax_ff;
      den_in   = den_ff;
      sign_in  = sign_ff;
      ylo_in   = ylo_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      num_in   = num_ff;
      neg_in   = neg_ff;
      ovf_in   = ovf_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      res_in   = res_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               ax_in    = ax;
               den_in   = den;
               sign_in  = sign_diff;
               ylo_in   = ylo;
               hi_in    = '0;
               lo_in    = ay;
               cnt_in   = '0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            hi_in  = {1'b0, total[KW:1]};
            lo_in  = {total[0], lo_ff[PW-1:1]};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_MUL) begin
               state_in = S_ADJ;
            end
         end
         S_ADJ: begin
            num_in   = num_now;
            neg_in   = neg_now && !rounds_zero;
            ovf_in   = 1'b0;
            quo_in   = '0;
            state_in = rounds_zero ? S_FIN : S_CMP;
         end
         S_CMP: begin
            ovf_in   = ovf_now;
            rem_in   = num_ext[QB +: KW+1];
            quo_in   = num_ext[QB-1:0];
            cnt_in   = '0;
            state_in = ovf_now ? S_FIN : S_DIV;
         end
         S_DIV: begin
            rem_in = carry ? total[KW:0] : opa[KW:0];
            quo_in = {quo_ff[QB-2:0], carry};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == LAST_DIV) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            res_in   = fin_res;
            done_in  = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
      ax_ff   <= ax_in;
      den_ff  <= den_in;
      sign_ff <= sign_in;
      ylo_ff  <= ylo_in;
      hi_ff   <= hi_in;
      lo_ff   <= lo_in;
      num_ff  <= num_in;
      neg_ff  <= neg_in;
      ovf_ff  <= ovf_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      res_ff  <= res_in;
   end

   assign status.busy = (state_ff != S_IDLE);
   assign status.done = done_ff;
   assign result      = res_ff;

   // A start is always taken, and completion is marked exactly when the unit goes idle.
   `PLKI_ASSERT_NEXT(a_start_runs, clock, reset, start, status.busy, "start not taken")
   `PLKI_ASSERT_NOW(a_done_idle, clock, reset, status.done, !status.busy, "done while busy")
   `PLKI_ASSERT_NOW(a_fall_done, clock, reset, $fell(status.busy), status.done,
      "finish without done")

endmodule

FILE: hdl/piecewise_linear_key_index.sv
// Learned key index: per-bucket minimum keys, a global maximum entry, and
// interpolated position queries. After reset the block clears all
// 2^BUCKET_BITS + 1 table entries before it takes the first word. An insert
// makes two table reads, each followed by a conditional write. A query runs
// through the shared adder of the interpolation unit, which handles one
// multiplier bit per cycle and then one quotient bit per cycle; the divide is
// skipped when a negative offset rounds to zero or the quotient saturates, and
// a query that faults does not start the unit. A response waits in its output
// register until it is taken, and the next request is accepted meanwhile; a
// query that finishes while the previous response still waits holds until
// that one is taken.
module piecewise_linear_key_index #(
   parameter int BUCKET_BITS = 10,
   parameter int KEY_BITS    = 42,
   parameter int POS_BITS    = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  plki_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output plki_pkg::rsp_type rsp_data
);

`include "piecewise_linear_key_index_assert.svh"

   localparam int KW          = KEY_BITS;
   localparam int PW          = POS_BITS;
   localparam int AW          = BUCKET_BITS + 1;
   localparam int NUM_ENTRIES = (1 << BUCKET_BITS) + 1;
   localparam int EW          = 1 + KW + PW;
   localparam int XW          = (PW > plki_pkg::PRED_FIELD_W) ? PW : plki_pkg::PRED_FIELD_W;

   localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_ENTRIES - 1);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_LO    = 3'd2;
   localparam logic [2:0] ST_HI    = 3'd3;
   localparam logic [2:0] ST_WAIT  = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   logic [2:0]                   state_ff, state_in;
   logic [AW-1:0]                clr_cnt_ff, clr_cnt_in;
   logic                         kind_ff, kind_in;
   logic [KW-1:0]                key_ff, key_in;
   logic [PW-1:0]                pos_ff, pos_in;
   logic [AW-1:0]                bkt_ff, bkt_in;
   logic [KW-1:0]                xlo_ff, xlo_in;
   logic [PW-1:0]                ylo_ff, ylo_in;
   logic                         vlo_ff, vlo_in;
   logic [plki_pkg::FAULT_W-1:0] fault_ff, fault_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   plki_pkg::rsp_type            rsp_data_ff, rsp_data_in;

   // Request fields cut to the configured widths.
   logic [KW+plki_pkg::KEY_FIELD_W-1:0] key_wide;
   logic [PW+plki_pkg::POS_FIELD_W-1:0] pos_wide;
   logic [KW-1:0]                       req_key;
   logic [PW-1:0]                       req_pos;
   logic [BUCKET_BITS-1:0]              req_bkt;

   // Table port.
   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [EW-1:0] wr_data, rd_data;
   logic          rd_vld;
   logic [KW-1:0] rd_key;
   logic [PW-1:0] rd_pos;

   // Interpolation unit.
   logic                        start;
   logic                        neg_x, neg_y;
   logic [KW-1:0]               ax, den;
   logic [PW-1:0]               ay;
   plki_pkg::interp_status_type ist;
   logic [PW-1:0]               interp_res;
   logic [XW-1:0]               pred_wide;

   assign key_wide = (KW+plki_pkg::KEY_FIELD_W)'(req_data.key);
   assign pos_wide = (PW+plki_pkg::POS_FIELD_W)'(req_data.position);
   assign req_key  = key_wide[KW-1:0];
   assign req_pos  = pos_wide[PW-1:0];

   // Bucket is the top key bits, or the whole key when it is narrower.
   generate
      if (KEY_BITS >= BUCKET_BITS) begin : g_bkt_top
         assign req_bkt = req_key[KW-1 -: BUCKET_BITS];
      end else begin : g_bkt_low
         assign req_bkt = BUCKET_BITS'(req_key);
      end
   endgenerate

   assign rd_vld = rd_data[EW-1];
   assign rd_key = rd_data[PW +: KW];
   assign rd_pos = rd_data[PW-1:0];

   // Interpolation operands from the low entry and the freshly read high entry.
   always_comb begin
      neg_x = key_ff < xlo_ff;
      ax    = neg_x ? (xlo_ff - key_ff) : (key_ff - xlo_ff);
      neg_y = rd_pos < ylo_ff;
      ay    = neg_y ? (ylo_ff - rd_pos) : (rd_pos - ylo_ff);
      den   = rd_key - xlo_ff;
   end

   assign pred_wide = XW'(interp_res);

   // Table sequencer.
   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      kind_in      = kind_ff;
      key_in       = key_ff;
      pos_in       = pos_ff;
      bkt_in       = bkt_ff;
      xlo_in       = xlo_ff;
      ylo_in       = ylo_ff;
      vlo_in       = vlo_ff;
      fault_in     = fault_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = bkt_ff;
      wr_data      = {1'b1, key_ff, pos_ff};
      rd_addr      = bkt_ff;
      start        = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en      = 1'b1;
            wr_addr    = clr_cnt_ff;
            wr_data    = '0;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            rd_addr = AW'(req_bkt);
            if (req_valid) begin
               kind_in  = req_data.kind;
               key_in   = req_key;
               pos_in   = req_pos;
               bkt_in   = AW'(req_bkt);
               state_in = ST_LO;
            end
         end
         ST_LO: begin
            if (kind_ff == plki_pkg::KIND_INSERT) begin
               // The bucket keeps its smallest key; ties keep the older entry.
               wr_en   = !rd_vld || (rd_key > key_ff);
               wr_addr = bkt_ff;
               rd_addr = LAST_ADDR;
            end else begin
               xlo_in  = rd_key;
               ylo_in  = rd_pos;
               vlo_in  = rd_vld;
               rd_addr = bkt_ff + 1'b1;
            end
            state_in = ST_HI;
         end
         ST_HI: begin
            if (kind_ff == plki_pkg::KIND_INSERT) begin
               // The final entry keeps the largest key overall.
               wr_en    = !rd_vld || (key_ff > rd_key);
               wr_addr  = LAST_ADDR;
               state_in = ST_IDLE;
            end else if (!vlo_ff || !rd_vld) begin
               fault_in = plki_pkg::FAULT_EMPTY;
               state_in = ST_OUT;
            end else if (rd_key <= xlo_ff) begin
               fault_in = plki_pkg::FAULT_SPAN;
               state_in = ST_OUT;
            end else begin
               start    = 1'b1;
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (ist.done) begin
               fault_in = plki_pkg::FAULT_OK;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.fault = fault_ff;
               rsp_data_in.prediction = (fault_ff == plki_pkg::FAULT_OK) ?
                  pred_wide[plki_pkg::PRED_FIELD_W-1:0] : '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff     <= kind_in;
      key_ff      <= key_in;
      pos_ff      <= pos_in;
      bkt_ff      <= bkt_in;
      xlo_ff      <= xlo_in;
      ylo_ff      <= ylo_in;
      vlo_ff      <= vlo_in;
      fault_ff    <= fault_in;
      rsp_data_ff <= rsp_data_in;
   end

   plki_ram #(
      .WIDTH (EW),
      .DEPTH (NUM_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   plki_interp #(
      .KEY_BITS (KEY_BITS),
      .POS_BITS (POS_BITS)
   ) u_interp (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .ax        (ax),
      .ay        (ay),
      .den       (den),
      .sign_diff (neg_x != neg_y),
      .ylo       (ylo_ff),
      .status    (ist),
      .result    (interp_res)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The sequencer and the interpolation unit stay in step.
   `PLKI_ASSERT_NOW(a_ready_unit_idle, clock, reset, req_ready, !ist.busy,
      "ready while unit busy")
   `PLKI_ASSERT_NEXT(a_accept_drops_ready, clock, reset, req_valid && req_ready, !req_ready,
      "ready held after accept")
   `PLKI_ASSERT_NOW(a_done_in_wait, clock, reset, ist.done, state_ff == ST_WAIT,
      "unit done outside wait")
   `PLKI_ASSERT_NOW(a_fault_zero_pred, clock, reset,
      rsp_valid && (rsp_data.fault != plki_pkg::FAULT_OK), rsp_data.prediction == '0,
      "fault with prediction")

endmodule
